>>> rtl/gpt_pkg.sv
// ----------------------------------------------------------------------------
// gpt_pkg
// Shared types, codes and helpers for the grid pose tracker with visit map.
// ----------------------------------------------------------------------------
package gpt_pkg;

	// Grid size
	localparam int GRID_COLS = 15;
	localparam int GRID_ROWS = 8;
	localparam int MAP_DEPTH = GRID_COLS * GRID_ROWS;
	localparam int IDX_W     = $clog2(MAP_DEPTH);

	// Field widths
	localparam int OP_W   = 2;
	localparam int STEP_W = 3;
	localparam int COL_W  = 4;
	localparam int ROW_W  = 3;
	localparam int HEAD_W = 2;
	localparam int MARK_W = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam int IN_W  = 16;
	localparam int OUT_W = 16;

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);

	// Start position after reset
	localparam logic [COL_W-1:0] START_X_RST = 4'd7;
	localparam logic [ROW_W-1:0] START_Y_RST = 3'd7;

	// Operation codes
	localparam logic [OP_W-1:0] OP_STEP = 2'd0;
	localparam logic [OP_W-1:0] OP_DEAD = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

	// Step codes
	localparam logic [STEP_W-1:0] STEP_FWD   = 3'd0;
	localparam logic [STEP_W-1:0] STEP_RIGHT = 3'd1;
	localparam logic [STEP_W-1:0] STEP_BACK  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_LEFT  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_ABOUT = 3'd4;

	// Headings
	localparam logic [HEAD_W-1:0] HEAD_N = 2'd0;
	localparam logic [HEAD_W-1:0] HEAD_E = 2'd1;
	localparam logic [HEAD_W-1:0] HEAD_S = 2'd2;
	localparam logic [HEAD_W-1:0] HEAD_W_ = 2'd3;

	// Cell marks
	localparam logic [MARK_W-1:0] MARK_NONE    = 2'd0;
	localparam logic [MARK_W-1:0] MARK_VISITED = 2'd1;
	localparam logic [MARK_W-1:0] MARK_DEAD    = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_X = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 1'd1;

	// Where the result's cell value comes from
	localparam logic [1:0] SRC_CONST = 2'd0;
	localparam logic [1:0] SRC_RD    = 2'd1;
	localparam logic [1:0] SRC_CUR   = 2'd2;

	typedef struct packed {
		logic [ROW_W-1:0]  read_row;
		logic [COL_W-1:0]  read_col;
		logic [STEP_W-1:0] step_code;
		logic [OP_W-1:0]   operation;
	} item_t;

	typedef struct packed {
		logic              ok;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [HEAD_W-1:0] heading;
		logic [1:0]        src;
		logic [MARK_W-1:0] val;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [MARK_W-1:0] mark;
	} map_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx_a;
		logic [IDX_W-1:0] idx_b;
	} map_rd_t;

	// Column-major cell address
	function automatic logic [IDX_W-1:0] cell_index(input logic [COL_W-1:0] col,
		input logic [ROW_W-1:0] row);
		logic [IDX_W-1:0] base;
		base = IDX_W'(IDX_W'(col) * IDX_W'(GRID_ROWS));
		return IDX_W'(base + IDX_W'(row));
	endfunction

	// Clamp a start column or row onto the grid
	function automatic logic [COL_W-1:0] sat_col(input logic [COL_W-1:0] x);
		return (x > COL_LAST) ? COL_LAST : x;
	endfunction

	function automatic logic [ROW_W-1:0] sat_row(input logic [ROW_W-1:0] y);
		return (y > ROW_LAST) ? ROW_LAST : y;
	endfunction

endpackage

>>> rtl/gpt_map.sv
// ----------------------------------------------------------------------------
// gpt_map
// Cell mark store: one write port, two registered read ports, per-entry
// valid bits so that a restart clears the whole map at once.
// ----------------------------------------------------------------------------
module gpt_map (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clear,
	input  logic [gpt_pkg::IDX_W-1:0]        start_idx,
	input  gpt_pkg::map_wr_t                 wr,
	input  gpt_pkg::map_rd_t                 rd,
	output logic [gpt_pkg::MARK_W-1:0]       mark_a,
	output logic [gpt_pkg::MARK_W-1:0]       mark_b
);

	logic [gpt_pkg::MARK_W-1:0] mem [gpt_pkg::MAP_DEPTH];
	logic [gpt_pkg::MAP_DEPTH-1:0] vld_q;

	logic [gpt_pkg::MARK_W-1:0] mem_a_q, mem_b_q;
	logic                       vld_a_q, vld_b_q;
	logic                       start_a_q, start_b_q;

	// Storage and registered reads
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.mark;
		end
		if (rd.en) begin
			mem_a_q   <= mem[rd.idx_a];
			mem_b_q   <= mem[rd.idx_b];
			start_a_q <= (rd.idx_a == start_idx);
			start_b_q <= (rd.idx_b == start_idx);
		end
	end

	// Valid bits: an entry never written reads as its reset mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			if (rd.en) begin
				vld_a_q <= vld_q[rd.idx_a];
				vld_b_q <= vld_q[rd.idx_b];
			end
		end
	end

	// Start cell reads as visited until written
	always_comb begin
		if (vld_a_q) begin
			mark_a = mem_a_q;
		end else begin
			mark_a = start_a_q ? gpt_pkg::MARK_VISITED : gpt_pkg::MARK_NONE;
		end
		if (vld_b_q) begin
			mark_b = mem_b_q;
		end else begin
			mark_b = start_b_q ? gpt_pkg::MARK_VISITED : gpt_pkg::MARK_NONE;
		end
	end

endmodule

>>> rtl/gpt_pose.sv
// ----------------------------------------------------------------------------
// gpt_pose
// Pose registers and the per-item step logic: heading table, bounds check,
// map write and read requests, and the result fields.
// ----------------------------------------------------------------------------
module gpt_pose (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gpt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gpt_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 go,
	input  gpt_pkg::item_t                       item,
	output logic                                 clear,
	output logic [gpt_pkg::IDX_W-1:0]            start_idx,
	output gpt_pkg::map_wr_t                     wr,
	output gpt_pkg::map_rd_t                     rd,
	output gpt_pkg::res_t                        res
);

	logic [gpt_pkg::COL_W-1:0]  start_x_q, start_col_q, cur_col_q;
	logic [gpt_pkg::ROW_W-1:0]  start_y_q, start_row_q, cur_row_q;
	logic [gpt_pkg::HEAD_W-1:0] facing_q;

	logic [gpt_pkg::COL_W-1:0]  new_x, nc;
	logic [gpt_pkg::ROW_W-1:0]  new_y, nr;
	logic [gpt_pkg::HEAD_W-1:0] nf, dir;
	logic                       moves, in_grid, rd_inside;
	logic [gpt_pkg::IDX_W-1:0]  cur_idx;

	// Restart on any register write
	assign clear = cfg_we;
	assign new_x = (cfg_index == gpt_pkg::REG_START_X) ? cfg_data : start_x_q;
	assign new_y = (cfg_index == gpt_pkg::REG_START_Y) ?
		cfg_data[gpt_pkg::ROW_W-1:0] : start_y_q;

	assign start_idx = gpt_pkg::cell_index(start_col_q, start_row_q);
	assign cur_idx   = gpt_pkg::cell_index(cur_col_q, cur_row_q);

	// Heading table and move direction
	always_comb begin
		nf    = facing_q;
		dir   = facing_q;
		moves = 1'b1;
		unique case (item.step_code)
			gpt_pkg::STEP_FWD: begin
				dir = facing_q;
			end
			gpt_pkg::STEP_RIGHT: begin
				nf  = facing_q + 2'd1;
				dir = nf;
			end
			gpt_pkg::STEP_BACK: begin
				dir = facing_q + 2'd2;
			end
			gpt_pkg::STEP_LEFT: begin
				nf  = facing_q + 2'd3;
				dir = nf;
			end
			gpt_pkg::STEP_ABOUT: begin
				nf    = facing_q + 2'd2;
				moves = 1'b0;
			end
			default: begin
				moves = 1'b0;
			end
		endcase
	end

	// Next cell and bounds check
	always_comb begin
		nc      = cur_col_q;
		nr      = cur_row_q;
		in_grid = 1'b1;
		unique case (dir)
			gpt_pkg::HEAD_N: begin
				if (cur_row_q == '0) in_grid = 1'b0;
				else nr = cur_row_q - 3'd1;
			end
			gpt_pkg::HEAD_E: begin
				if (cur_col_q == gpt_pkg::COL_LAST) in_grid = 1'b0;
				else nc = cur_col_q + 4'd1;
			end
			gpt_pkg::HEAD_S: begin
				if (cur_row_q == gpt_pkg::ROW_LAST) in_grid = 1'b0;
				else nr = cur_row_q + 3'd1;
			end
			default: begin
				if (cur_col_q == '0) in_grid = 1'b0;
				else nc = cur_col_q - 4'd1;
			end
		endcase
	end

	assign rd_inside = (item.read_col <= gpt_pkg::COL_LAST) &&
		(item.read_row <= gpt_pkg::ROW_LAST);

	// Map requests and result fields
	always_comb begin
		wr.en   = 1'b0;
		wr.idx  = cur_idx;
		wr.mark = gpt_pkg::MARK_VISITED;
		rd.en   = go;
		rd.idx_a = rd_inside ? gpt_pkg::cell_index(item.read_col, item.read_row) : cur_idx;
		rd.idx_b = cur_idx;
		res.ok      = 1'b0;
		res.col     = cur_col_q;
		res.row     = cur_row_q;
		res.heading = facing_q;
		res.src     = gpt_pkg::SRC_CUR;
		res.val     = gpt_pkg::MARK_NONE;
		unique case (item.operation)
			gpt_pkg::OP_STEP: begin
				res.heading = nf;
				if (!moves) begin
					wr.en   = go;
					res.ok  = 1'b1;
					res.src = gpt_pkg::SRC_CONST;
					res.val = gpt_pkg::MARK_VISITED;
				end else if (in_grid) begin
					wr.en   = go;
					wr.idx  = gpt_pkg::cell_index(nc, nr);
					res.ok  = 1'b1;
					res.col = nc;
					res.row = nr;
					res.src = gpt_pkg::SRC_CONST;
					res.val = gpt_pkg::MARK_VISITED;
				end
			end
			gpt_pkg::OP_DEAD: begin
				wr.en   = go;
				wr.mark = gpt_pkg::MARK_DEAD;
				res.src = gpt_pkg::SRC_CONST;
				res.val = gpt_pkg::MARK_DEAD;
			end
			gpt_pkg::OP_READ: begin
				res.src = rd_inside ? gpt_pkg::SRC_RD : gpt_pkg::SRC_CONST;
			end
			gpt_pkg::OP_NOP: begin
				res.src = gpt_pkg::SRC_CUR;
			end
			default: begin
				res.src = gpt_pkg::SRC_CUR;
			end
		endcase
	end

	// Pose and start registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q   <= gpt_pkg::START_X_RST;
			start_y_q   <= gpt_pkg::START_Y_RST;
			start_col_q <= gpt_pkg::sat_col(gpt_pkg::START_X_RST);
			start_row_q <= gpt_pkg::sat_row(gpt_pkg::START_Y_RST);
			cur_col_q   <= gpt_pkg::sat_col(gpt_pkg::START_X_RST);
			cur_row_q   <= gpt_pkg::sat_row(gpt_pkg::START_Y_RST);
			facing_q    <= gpt_pkg::HEAD_N;
		end else if (cfg_we) begin
			start_x_q   <= new_x;
			start_y_q   <= new_y;
			start_col_q <= gpt_pkg::sat_col(new_x);
			start_row_q <= gpt_pkg::sat_row(new_y);
			cur_col_q   <= gpt_pkg::sat_col(new_x);
			cur_row_q   <= gpt_pkg::sat_row(new_y);
			facing_q    <= gpt_pkg::HEAD_N;
		end else if (go) begin
			cur_col_q <= res.col;
			cur_row_q <= res.row;
			facing_q  <= res.heading;
		end
	end

endmodule

>>> rtl/grid_pose_tracker_visit_map.sv
// ----------------------------------------------------------------------------
// grid_pose_tracker_visit_map
// Tracks heading and cell of a robot on a 15 x 8 grid and keeps a 2-bit mark
// per cell (unvisited, visited, dead end).
//
// One request is taken per cycle while the result stream is not stalled, and
// each gives one result: it is held in the input register, then in the result
// register beside the map's registered read port. Pose updates and map writes
// settle in the same cycle, so back-to-back requests see each other's effects.
// A register write restarts the tracker at once (heading north, map cleared
// through per-cell valid bits, start cell reads as visited); write registers
// only while no request is in flight.
// ----------------------------------------------------------------------------
module grid_pose_tracker_visit_map (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration
	input  logic                               cfg_we,
	input  logic [gpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gpt_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Request stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [1:0] operation, [4:2] step_code, [8:5] read_col, [11:9] read_row, rest 0
	input  logic [gpt_pkg::IN_W-1:0]           s_axis_tdata,
	// Result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] ok, [4:1] pos_col, [7:5] pos_row, [9:8] heading, [11:10] cell_value
	output logic [gpt_pkg::OUT_W-1:0]          m_axis_tdata
);

	logic                  vld_s1, vld_s2;
	gpt_pkg::item_t        item_s1;
	gpt_pkg::res_t         res, res_s2;
	logic                  adv, go;
	logic                  clear;
	logic [gpt_pkg::IDX_W-1:0]  start_idx;
	gpt_pkg::map_wr_t      wr;
	gpt_pkg::map_rd_t      rd;
	logic [gpt_pkg::MARK_W-1:0] mark_a, mark_b;
	logic [gpt_pkg::MARK_W-1:0] cell_value;

	// Handshake
	assign adv           = !vld_s2 || m_axis_tready;
	assign go            = vld_s1 && adv;
	assign s_axis_tready = !vld_s1 || adv;
	assign m_axis_tvalid = vld_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= gpt_pkg::item_t'(s_axis_tdata[11:0]);
		end
	end

	gpt_pose u_pose (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.go        (go),
		.item      (item_s1),
		.clear     (clear),
		.start_idx (start_idx),
		.wr        (wr),
		.rd        (rd),
		.res       (res)
	);

	gpt_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.start_idx (start_idx),
		.wr        (wr),
		.rd        (rd),
		.mark_a    (mark_a),
		.mark_b    (mark_b)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_s2 <= res;
		end
	end

	// Cell value select
	always_comb begin
		unique case (res_s2.src)
			gpt_pkg::SRC_RD:  cell_value = mark_a;
			gpt_pkg::SRC_CUR: cell_value = mark_b;
			default:          cell_value = res_s2.val;
		endcase
	end

	assign m_axis_tdata = {4'd0, cell_value, res_s2.heading, res_s2.row, res_s2.col, res_s2.ok};

endmodule
